// File: rtl/mrt_pkg.sv
// Package holding the constants and types shared by the mapped region table.
`default_nettype none
package mrt_pkg;
    localparam int REGION_SLOTS = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W = 38;
    localparam int OFFS_W = 40;
    localparam logic [37:0] TOP_RESET = 38'h3FFFFFE000;
    localparam logic [1:0] OP_MAP = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;
    localparam logic CFG_HEAP_TOP = 1'b0;
    localparam logic CFG_TOP_ADDRESS = 1'b1;

    typedef struct packed {
        logic [37:0] base;
        logic [37:0] len;
        logic [2:0]  prot;
        logic        shared;
        logic [39:0] offset;
        logic [7:0]  file;
    } slot_t;
endpackage
`default_nettype wire

// File: rtl/mapped_region_table_core.sv
// Top level of the mapped region table: request sequencer around one slot memory.
// Each request makes one pass over the slot memory, one read per cycle, then a decide step and,
// for a successful map or unmap, two slot write steps before the result word is offered.
// One request is worked on at a time; the next is taken once the result word has left.
// Reset clears the slot used bits and sets heap_top to 0 and top_address to 0x3FFFFFE000.
// The slot memory itself needs no clearing pass; its entries are acted on only while in use.
`default_nettype none
module mapped_region_table_core #(
    parameter int REGION_SLOTS = mrt_pkg::REGION_SLOTS,
    parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [37:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [30:0] s_length,
    input  wire logic [7:0]  s_prot,
    input  wire logic [1:0]  s_share_mode,
    input  wire logic        s_file_ok,
    input  wire logic        s_file_writable,
    input  wire logic [7:0]  s_file_id,
    input  wire logic [30:0] s_file_offset,
    input  wire logic [37:0] s_address,
    input  wire logic        s_is_write,
    input  wire logic        s_already_mapped,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [37:0]      m_result_addr,
    output logic [37:0]      m_range_len,
    output logic [39:0]      m_file_offset_out,
    output logic [7:0]       m_file_id_out,
    output logic [3:0]       m_page_perm,
    output logic             m_shared_out,
    output logic signed [1:0] m_file_ref_change
);
    localparam int IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] LAST = CW'(REGION_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_WRITE1, ST_WRITE2, ST_OUT
    } state_t;

    state_t state_reg;
    logic [37:0] heap_top_reg, top_address_reg;
    logic [REGION_SLOTS-1:0] used_reg;
    mrt_pkg::slot_t mem [REGION_SLOTS];
    mrt_pkg::slot_t rd_reg, hit_reg;
    logic [CW-1:0] cnt_reg;
    logic rd_ok_reg;
    logic [IW-1:0] rd_idx_reg, hit_idx_reg, free_idx_reg;
    logic hit_found_reg, free_found_reg;
    logic [37:0] lo_reg;

    logic [1:0]  op_reg;
    logic [30:0] length_reg, foff_reg;
    logic [7:0]  prot_reg, fid_reg;
    logic [1:0]  share_reg;
    logic        fok_reg, fwr_reg, isw_reg, mapd_reg;
    logic [37:0] addr_reg;

    logic        wr_en;
    logic [IW-1:0] wr_idx;
    mrt_pkg::slot_t wr_data;

    logic        st_reg;
    logic [37:0] ra_reg, rl_reg;
    logic [39:0] fo_reg;
    logic [7:0]  fi_reg;
    logic [3:0]  pp_reg;
    logic        sh_reg;
    logic [1:0]  rc_reg;

    // write work of the decide step
    logic        pend2_reg;
    mrt_pkg::slot_t w2_reg;
    logic [IW-1:0] w2_idx_reg;

    logic [37:0] len_map, len_un, rd_end, n_raw, n_cl, s_end;
    logic        in_rng, args_ok;
    assign len_map = 38'((39'(length_reg) + 39'(PAGE_BYTES - 1)) >> PB << PB);
    assign len_un = len_map;
    assign rd_end = rd_reg.base + rd_reg.len;
    assign in_rng = addr_reg >= rd_reg.base && addr_reg < rd_end;
    assign args_ok = length_reg != 31'd0 && prot_reg[7:3] == 5'd0
        && (share_reg == 2'd1 || share_reg == 2'd2) && fok_reg
        && !(prot_reg[1] && share_reg == 2'd1 && !fwr_reg);
    assign s_end = hit_reg.base + hit_reg.len;
    assign n_raw = s_end - addr_reg;
    assign n_cl = (n_raw > len_un) ? len_un : n_raw;

    assign s_ready = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid = state_reg == ST_OUT;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_reg <= mem[cnt_reg[IW-1:0]];
    end

    always_comb begin
        wr_en = 1'b0;
        wr_idx = hit_idx_reg;
        wr_data = hit_reg;
        if (state_reg == ST_WRITE1) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_WRITE2) begin
            wr_en = pend2_reg;
            wr_idx = w2_idx_reg;
            wr_data = w2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            heap_top_reg <= 38'd0;
            top_address_reg <= mrt_pkg::TOP_RESET;
            used_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == mrt_pkg::CFG_HEAP_TOP) heap_top_reg <= cfg_data;
                else top_address_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_op; length_reg <= s_length; prot_reg <= s_prot;
                        share_reg <= s_share_mode; fok_reg <= s_file_ok;
                        fwr_reg <= s_file_writable; fid_reg <= s_file_id;
                        foff_reg <= s_file_offset; addr_reg <= s_address;
                        isw_reg <= s_is_write; mapd_reg <= s_already_mapped;
                        cnt_reg <= '0; rd_ok_reg <= 1'b0;
                        hit_found_reg <= 1'b0; free_found_reg <= 1'b0;
                        lo_reg <= top_address_reg;
                        pend2_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_ok_reg) begin
                        if (used_reg[rd_idx_reg]) begin
                            if (rd_reg.base < lo_reg) lo_reg <= rd_reg.base;
                            if (in_rng && !hit_found_reg) begin
                                hit_found_reg <= 1'b1;
                                hit_idx_reg <= rd_idx_reg;
                                hit_reg <= rd_reg;
                            end
                        end else if (!free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                    rd_idx_reg <= cnt_reg[IW-1:0];
                    rd_ok_reg <= cnt_reg != LAST;
                    if (cnt_reg == LAST) state_reg <= ST_DECIDE;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DECIDE: begin
                    st_reg <= 1'b1; ra_reg <= '0; rl_reg <= '0; fo_reg <= '0;
                    fi_reg <= '0; pp_reg <= '0; sh_reg <= 1'b0; rc_reg <= 2'd0;
                    state_reg <= ST_OUT;
                    case (op_reg)
                        mrt_pkg::OP_MAP: begin
                            if (args_ok && free_found_reg && len_map <= lo_reg
                                && lo_reg - len_map >= heap_top_reg) begin
                                st_reg <= 1'b0; ra_reg <= lo_reg - len_map;
                                rl_reg <= len_map; fo_reg <= 40'(foff_reg);
                                fi_reg <= fid_reg; sh_reg <= share_reg == 2'd1;
                                rc_reg <= 2'd1;
                                hit_idx_reg <= free_idx_reg;
                                hit_reg <= '{base: lo_reg - len_map, len: len_map,
                                    prot: prot_reg[2:0], shared: share_reg == 2'd1,
                                    offset: 40'(foff_reg), file: fid_reg};
                                used_reg[free_idx_reg] <= 1'b1;
                                state_reg <= ST_WRITE1;
                            end
                        end
                        mrt_pkg::OP_UNMAP: begin
                            if (addr_reg[PB-1:0] == '0 && length_reg != 31'd0
                                && hit_found_reg && (addr_reg == hit_reg.base
                                || addr_reg + n_cl == s_end || free_found_reg)) begin
                                st_reg <= 1'b0; ra_reg <= addr_reg; rl_reg <= n_cl;
                                fo_reg <= hit_reg.offset + 40'(addr_reg - hit_reg.base);
                                fi_reg <= hit_reg.file; sh_reg <= hit_reg.shared;
                                state_reg <= ST_WRITE1;
                                if (addr_reg == hit_reg.base) begin
                                    hit_reg.base <= hit_reg.base + n_cl;
                                    hit_reg.offset <= hit_reg.offset + 40'(n_cl);
                                    hit_reg.len <= hit_reg.len - n_cl;
                                end else if (addr_reg + n_cl == s_end) begin
                                    hit_reg.len <= hit_reg.len - n_cl;
                                end else begin
                                    pend2_reg <= 1'b1; w2_idx_reg <= free_idx_reg;
                                    used_reg[free_idx_reg] <= 1'b1;
                                    w2_reg <= '{base: addr_reg + n_cl,
                                        len: s_end - (addr_reg + n_cl),
                                        prot: hit_reg.prot, shared: hit_reg.shared,
                                        offset: hit_reg.offset
                                            + 40'(addr_reg + n_cl - hit_reg.base),
                                        file: hit_reg.file};
                                    hit_reg.len <= addr_reg - hit_reg.base;
                                    rc_reg <= 2'd1;
                                end
                                if (hit_reg.len == n_cl) begin
                                    used_reg[hit_idx_reg] <= 1'b0;
                                    rc_reg <= 2'b11;
                                end
                            end
                        end
                        mrt_pkg::OP_FAULT: begin
                            if (hit_found_reg && !mapd_reg && (isw_reg ? hit_reg.prot[1]
                                : (hit_reg.prot[0] | hit_reg.prot[2]))) begin
                                st_reg <= 1'b0;
                                fo_reg <= hit_reg.offset + 40'(addr_reg - hit_reg.base);
                                fi_reg <= hit_reg.file;
                                pp_reg <= {1'b1, hit_reg.prot[2], hit_reg.prot[1], 1'b1};
                                sh_reg <= hit_reg.shared;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_WRITE1: state_reg <= ST_WRITE2;
                ST_WRITE2: state_reg <= ST_OUT;
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_status = st_reg;
    assign m_result_addr = ra_reg;
    assign m_range_len = rl_reg;
    assign m_file_offset_out = fo_reg;
    assign m_file_id_out = fi_reg;
    assign m_page_perm = pp_reg;
    assign m_shared_out = sh_reg;
    assign m_file_ref_change = rc_reg;

`ifndef NO_ASSERTIONS
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_range_len == '0 && m_file_ref_change == 2'd0)
        else $error("failed result carries data");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_addr))
        else $error("result word changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted with result pending");
    a_perm_user: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_page_perm != 4'd0 |-> m_page_perm[3] && m_page_perm[0])
        else $error("page permission lacks user or read");
`endif
endmodule
`default_nettype wire
